// ----- rtl/rbb_pkg.sv -----
// Shared types, widths and codes for the renko brick builder.
`timescale 1ns / 1ps
`default_nettype none

package rbb_pkg;

	localparam int PRICE_WIDTH = 32;
	localparam int TIME_WIDTH  = 32;
	localparam int SIZE_WIDTH  = 16;
	localparam int CNT_WIDTH   = 32;

	localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(10);
	localparam logic [CNT_WIDTH-1:0]  CNT_MAX    = {CNT_WIDTH{1'b1}};

	localparam int IN_W       = PRICE_WIDTH + TIME_WIDTH;
	localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W      = 2 * PRICE_WIDTH + 2 * TIME_WIDTH + CNT_WIDTH;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 8;

	localparam int ADDR_WIDTH = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_BRICK_SIZE = 1'b0;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_ANCHOR = 2'd1,
		PH_RUN    = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   last_down;
		logic [PRICE_WIDTH-1:0] last_open_price;
		logic [PRICE_WIDTH-1:0] last_close_price;
		logic [TIME_WIDTH-1:0]  last_open_time;
		logic [TIME_WIDTH-1:0]  last_close_time;
		logic [PRICE_WIDTH-1:0] anchor_price;
		logic [TIME_WIDTH-1:0]  anchor_time;
		logic [CNT_WIDTH-1:0]   tick_counter;
	} state_t;

	typedef struct packed {
		logic                   down;
		logic [PRICE_WIDTH-1:0] open_px;
		logic [PRICE_WIDTH-1:0] close_px;
		logic [TIME_WIDTH-1:0]  open_ts;
		logic [TIME_WIDTH-1:0]  close_ts;
		logic [CNT_WIDTH-1:0]   ticks;
		logic                   reversal;
		logic                   first;
	} brick_t;

endpackage

`default_nettype wire

// ----- rtl/rbb_decide.sv -----
// Per-tick brick decision: next state and the brick a tick produces.
`timescale 1ns / 1ps
`default_nettype none

module rbb_decide
	import rbb_pkg::*;
(
	input  state_t                 cur,
	input  logic [PRICE_WIDTH-1:0] bid,
	input  logic [TIME_WIDTH-1:0]  tick_time,
	input  logic [SIZE_WIDTH-1:0]  brick_size,
	output state_t                 nxt,
	output logic                   emit,
	output brick_t                 brick
);

	function automatic logic moves_up(input logic [PRICE_WIDTH-1:0] hi,
			input logic [PRICE_WIDTH-1:0] lo, input logic [PRICE_WIDTH-1:0] sz);
		logic [PRICE_WIDTH-1:0] diff;
		diff = hi - lo;
		return (hi > lo) && (diff >= sz);
	endfunction

	logic [PRICE_WIDTH-1:0] sz;
	logic [CNT_WIDTH-1:0]   cnt_inc;
	logic                   up_anchor, dn_anchor, up_close, dn_close, up_open, dn_open;
	logic                   down;
	logic                   rev;
	logic                   first;
	logic [PRICE_WIDTH-1:0] base_price;
	logic [TIME_WIDTH-1:0]  base_time;

	assign sz      = PRICE_WIDTH'(brick_size);
	assign cnt_inc = (cur.tick_counter == CNT_MAX) ? cur.tick_counter
		: cur.tick_counter + CNT_WIDTH'(1);

	assign up_anchor = moves_up(bid, cur.anchor_price, sz);
	assign dn_anchor = moves_up(cur.anchor_price, bid, sz);
	assign up_close  = moves_up(bid, cur.last_close_price, sz);
	assign dn_close  = moves_up(cur.last_close_price, bid, sz);
	assign up_open   = moves_up(bid, cur.last_open_price, sz);
	assign dn_open   = moves_up(cur.last_open_price, bid, sz);

	always_comb begin
		emit       = 1'b0;
		down       = 1'b0;
		rev        = 1'b0;
		first      = 1'b0;
		base_price = cur.last_close_price;
		base_time  = cur.last_close_time;
		unique case (cur.phase)
			PH_WAIT: begin
			end
			PH_ANCHOR: begin
				base_price = cur.anchor_price;
				base_time  = cur.anchor_time;
				first      = 1'b1;
				if (up_anchor) begin
					emit = 1'b1;
				end else if (dn_anchor) begin
					emit = 1'b1;
					down = 1'b1;
				end
			end
			default: begin
				if (!cur.last_down) begin
					if (up_close) begin
						emit = 1'b1;
					end else if (dn_open) begin
						emit       = 1'b1;
						down       = 1'b1;
						rev        = 1'b1;
						base_price = cur.last_open_price;
						base_time  = cur.last_open_time;
					end
				end else begin
					if (dn_close) begin
						emit = 1'b1;
						down = 1'b1;
					end else if (up_open) begin
						emit       = 1'b1;
						rev        = 1'b1;
						base_price = cur.last_open_price;
						base_time  = cur.last_open_time;
					end
				end
			end
		endcase
	end

	always_comb begin
		brick.down     = down;
		brick.open_px  = base_price;
		brick.close_px = down ? base_price - sz : base_price + sz;
		brick.open_ts  = base_time;
		brick.close_ts = tick_time;
		brick.ticks    = cnt_inc;
		brick.reversal = rev;
		brick.first    = first;
	end

	always_comb begin
		nxt = cur;
		if (cur.phase == PH_WAIT) begin
			nxt.anchor_price = bid;
			nxt.anchor_time  = tick_time;
			nxt.tick_counter = CNT_WIDTH'(1);
			nxt.phase        = PH_ANCHOR;
		end else if (emit) begin
			nxt.last_down        = down;
			nxt.last_open_price  = brick.open_px;
			nxt.last_close_price = brick.close_px;
			nxt.last_open_time   = brick.open_ts;
			nxt.last_close_time  = brick.close_ts;
			nxt.tick_counter     = CNT_WIDTH'(1);
			nxt.phase            = PH_RUN;
		end else begin
			nxt.tick_counter = cnt_inc;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/renko_brick_builder.sv -----
// A tick is registered at the input, decided, and its brick registered at the output.
// Throughput: one tick per cycle, unless a brick meets a full, stalled output register;
// the state update closes in the single decide stage, and a tick producing no brick
// never waits on the output side. Reset (arst_n low, asynchronous): state returns
// to waiting for the first tick, brick size returns to 10, both stream sides empty.
`timescale 1ns / 1ps
`default_nettype none

module renko_brick_builder
	import rbb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // bid_points, tick_time
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// brick_open_price, brick_close_price, brick_open_time, brick_close_time, brick_ticks
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [OUT_USER_W-1:0] m_axis_tuser,  // brick_down, brick_reversal, brick_first
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [SIZE_WIDTH-1:0]  brick_size_q;
	logic                   valid_s1;
	logic [PRICE_WIDTH-1:0] bid_s1;
	logic [TIME_WIDTH-1:0]  time_s1;
	state_t                 state_q;
	state_t                 state_nxt;
	logic                   emit;
	brick_t                 brick;
	brick_t                 brick_q;
	logic                   out_valid_q;
	logic                   advance;
	logic                   reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_WIDTH-1] == REG_BRICK_SIZE);
	assign prdata  = reg_sel ? APB_DATA_W'(brick_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brick_size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			brick_size_q <= pwdata[SIZE_WIDTH-1:0];
		end
	end

	rbb_decide u_decide (
		.cur        (state_q),
		.bid        (bid_s1),
		.tick_time  (time_s1),
		.brick_size (brick_size_q),
		.nxt        (state_nxt),
		.emit       (emit),
		.brick      (brick)
	);

	// a tick without a brick leaves regardless of the output register
	assign advance       = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			bid_s1  <= s_axis_tdata[PRICE_WIDTH-1:0];
			time_s1 <= s_axis_tdata[IN_W-1:PRICE_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_WAIT, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			brick_q <= brick;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({brick_q.ticks, brick_q.close_ts, brick_q.open_ts,
		brick_q.close_px, brick_q.open_px});
	assign m_axis_tuser  = OUT_USER_W'({brick_q.first, brick_q.reversal, brick_q.down});

`ifndef NO_ASSERTIONS
	a_first_not_rev: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(brick_q.first && brick_q.reversal))
		else $error("first brick flagged as reversal");

	a_ticks_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (brick_q.ticks != '0))
		else $error("brick with zero tick count");

	a_run_after_brick: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (state_q.phase == PH_RUN))
		else $error("state not running after a brick");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room available");

	a_count_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (state_q.tick_counter == CNT_WIDTH'(1)))
		else $error("tick count not restarted after brick");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking stream testbench for the renko brick builder: directed and random-walk ticks.
`timescale 1ns / 1ps

module tb_top;
	import rbb_pkg::*;

	localparam int REG_COUNT = 1;
	localparam logic [ADDR_WIDTH-1:0] ADDR_BRICK_SIZE = ADDR_WIDTH'(4 * int'(REG_BRICK_SIZE));
	localparam logic [ADDR_WIDTH-1:0] ADDR_NO_REG     = ADDR_WIDTH'(4 * REG_COUNT);
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_TICKS = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // bid_points, tick_time
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// brick_open_price, brick_close_price, brick_open_time, brick_close_time, brick_ticks
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;   // brick_down, brick_reversal, brick_first
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	renko_brick_builder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Shadow copy of the brick builder state
	logic [SIZE_WIDTH-1:0]  brick_size;
	phase_t                 run_phase;
	logic                   last_down;
	logic [PRICE_WIDTH-1:0] last_open_px;
	logic [PRICE_WIDTH-1:0] last_close_px;
	logic [TIME_WIDTH-1:0]  last_open_t;
	logic [TIME_WIDTH-1:0]  last_close_t;
	logic [PRICE_WIDTH-1:0] anchor_px;
	logic [TIME_WIDTH-1:0]  anchor_t;
	logic [CNT_WIDTH-1:0]   tick_cnt;

	brick_t expected_bricks[$];

	int err_cnt;
	int ticks_sent;
	int bricks_seen;
	int idle_cycles;
	int sink_hold;
	bit sink_idle_en;
	bit src_idle_en;
	logic [PRICE_WIDTH-1:0] walk_px;

	always #6 clk = ~clk;

	function automatic void close_brick(input logic down,
			input logic [PRICE_WIDTH-1:0] op, input logic [PRICE_WIDTH-1:0] cp,
			input logic [TIME_WIDTH-1:0] ot, input logic [TIME_WIDTH-1:0] ct,
			input logic rev, input logic first);
		brick_t b;
		b.down     = down;
		b.open_px  = op;
		b.close_px = cp;
		b.open_ts  = ot;
		b.close_ts = ct;
		b.ticks    = tick_cnt;
		b.reversal = rev;
		b.first    = first;
		expected_bricks = {expected_bricks, b};
		last_down     = down;
		last_open_px  = op;
		last_close_px = cp;
		last_open_t   = ot;
		last_close_t  = ct;
		tick_cnt      = 1;
		run_phase     = PH_RUN;
	endfunction

	function automatic void predict_brick(input logic [PRICE_WIDTH-1:0] bid,
			input logic [TIME_WIDTH-1:0] tt);
		logic [PRICE_WIDTH-1:0] sz;
		sz = PRICE_WIDTH'(brick_size);
		if (run_phase == PH_WAIT) begin
			anchor_px = bid;
			anchor_t  = tt;
			tick_cnt  = 1;
			run_phase = PH_ANCHOR;
			return;
		end
		if (tick_cnt != CNT_MAX)
			tick_cnt++;
		if (run_phase == PH_ANCHOR) begin
			if (bid > anchor_px && bid - anchor_px >= sz)
				close_brick(1'b0, anchor_px, anchor_px + sz, anchor_t, tt, 1'b0, 1'b1);
			else if (bid < anchor_px && anchor_px - bid >= sz)
				close_brick(1'b1, anchor_px, anchor_px - sz, anchor_t, tt, 1'b0, 1'b1);
		end else if (!last_down) begin
			if (bid > last_close_px && bid - last_close_px >= sz)
				close_brick(1'b0, last_close_px, last_close_px + sz, last_close_t, tt,
					1'b0, 1'b0);
			else if (bid < last_open_px && last_open_px - bid >= sz)
				close_brick(1'b1, last_open_px, last_open_px - sz, last_open_t, tt,
					1'b1, 1'b0);
		end else begin
			if (bid < last_close_px && last_close_px - bid >= sz)
				close_brick(1'b1, last_close_px, last_close_px - sz, last_close_t, tt,
					1'b0, 1'b0);
			else if (bid > last_open_px && bid - last_open_px >= sz)
				close_brick(1'b0, last_open_px, last_open_px + sz, last_open_t, tt,
					1'b1, 1'b0);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!src_idle_en || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_tick(input logic [PRICE_WIDTH-1:0] bid, input logic [TIME_WIDTH-1:0] tt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tt, bid};
		do @(posedge clk); while (!s_axis_tready);
		predict_brick(bid, tt);
		ticks_sent++;
	endtask

	// drop valid and wait until every predicted brick has come out
	task automatic drain_bricks();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_bricks.size() != 0);
	endtask

	task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_BRICK_SIZE)
			brick_size = data[SIZE_WIDTH-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check_size();
		logic [APB_DATA_W-1:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= ADDR_BRICK_SIZE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[SIZE_WIDTH-1:0] !== brick_size) begin
			$error("brick_size_points mismatch: expected %0d, actual %0d",
				brick_size, rd[SIZE_WIDTH-1:0]);
			err_cnt++;
		end
	endtask

	task automatic set_brick_size(input logic [APB_DATA_W-1:0] data);
		drain_bricks();
		repeat (SETTLE_TICKS) @(posedge clk);
		apb_write(ADDR_BRICK_SIZE, data);
		apb_check_size();
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// brick checker
	always @(posedge clk) begin : brick_check
		brick_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			bricks_seen++;
			if (expected_bricks.size() == 0) begin
				$error("unexpected brick: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
				err_cnt++;
			end else begin
				e = expected_bricks.pop_front();
				check_field("brick_down", 32'(e.down), 32'(m_axis_tuser[0]));
				check_field("brick_reversal", 32'(e.reversal), 32'(m_axis_tuser[1]));
				check_field("brick_first", 32'(e.first), 32'(m_axis_tuser[2]));
				check_field("tuser_pad", 32'd0, 32'(m_axis_tuser[OUT_USER_W-1:3]));
				check_field("brick_open_price", e.open_px, m_axis_tdata[31:0]);
				check_field("brick_close_price", e.close_px, m_axis_tdata[63:32]);
				check_field("brick_open_time", e.open_ts, m_axis_tdata[95:64]);
				check_field("brick_close_time", e.close_ts, m_axis_tdata[127:96]);
				check_field("brick_ticks", e.ticks, m_axis_tdata[159:128]);
			end
		end
	end

	// output backpressure
	always @(posedge clk) begin : sink_stall
		int r;
		r = $urandom_range(0, 99);
		if (!sink_idle_en) begin
			m_axis_tready <= 1'b1;
		end else if (sink_hold == 0) begin
			if (r < 60) begin
				m_axis_tready <= 1'b1;
				sink_hold <= $urandom_range(1, 5);
			end else if (r < 95) begin
				m_axis_tready <= 1'b0;
				sink_hold <= $urandom_range(1, 3);
			end else begin
				m_axis_tready <= 1'b0;
				sink_hold <= $urandom_range(12, 50);
			end
		end else begin
			sink_hold <= sink_hold - 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic test_reset_and_register();
		apb_check_size();
		apb_write(ADDR_NO_REG, 32'h0000_0003);
		apb_check_size();
	endtask

	// size 10: first brick up, trend, reversal down, trend down, reversal up
	task automatic test_trend_and_reversal();
		send_tick(32'd100, 32'd1000);
		send_tick(32'd105, 32'd1001);
		send_tick(32'd95,  32'd1002);
		send_tick(32'd110, 32'd1003);
		send_tick(32'd119, 32'd1004);
		send_tick(32'd121, 32'd1005);
		send_tick(32'd101, 32'd1006);
		send_tick(32'd99,  32'd1007);
		send_tick(32'd89,  32'd1008);
		send_tick(32'd111, 32'd1009);
	endtask

	task automatic test_price_extremes();
		set_brick_size(32'h0000_FFFF);
		send_tick(32'hFFFF_FFFF, 32'h0000_0000);
		send_tick(32'h0000_0000, 32'hFFFF_FFFF);
		send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_brick_size(32'h0000_0001);
		send_tick(32'd131180, 32'd5);
		send_tick(32'h0000_0000, 32'h0000_0000);
	endtask

	// upper write bits must be dropped, leaving a zero-height brick
	task automatic test_zero_size();
		set_brick_size(32'hABCD_0000);
		send_tick(32'd65644, 32'd20);
		send_tick(32'd65645, 32'd21);
		send_tick(32'd65643, 32'd22);
		send_tick(32'd65643, 32'd23);
		send_tick(32'd65650, 32'd24);
		send_tick(32'd65651, 32'd25);
		walk_px = 32'd65651;
	endtask

	task automatic test_random_walk();
		logic [APB_DATA_W-1:0] sizes[7];
		int r;
		int span;
		logic [PRICE_WIDTH-1:0] stepv;
		sizes[0] = 32'd1;
		sizes[1] = $urandom_range(2, 30);
		sizes[2] = $urandom_range(31, 1000);
		sizes[3] = 32'h0000_FFFF;
		sizes[4] = {16'($urandom_range(0, 65535)), 16'h0000};
		sizes[5] = $urandom_range(1, 65535);
		sizes[6] = 32'd10;
		for (int p = 0; p < 7; p++) begin
			set_brick_size(sizes[p]);
			src_idle_en  = (p != 2);
			sink_idle_en = (p != 2);
			for (int i = 0; i < 75; i++) begin
				if (i == 37)
					drain_bricks();
				r = $urandom_range(0, 99);
				if (r < 8) begin
					walk_px = $urandom();
				end else if (r >= 13) begin
					span  = 2 * int'(brick_size) + 3;
					stepv = $urandom_range(0, span);
					if ($urandom_range(0, 1))
						walk_px = walk_px + stepv;
					else
						walk_px = walk_px - stepv;
				end
				send_tick(walk_px, $urandom());
			end
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		brick_size    = SIZE_RESET;
		run_phase     = PH_WAIT;
		last_down     = 1'b0;
		last_open_px  = '0;
		last_close_px = '0;
		last_open_t   = '0;
		last_close_t  = '0;
		anchor_px     = '0;
		anchor_t      = '0;
		tick_cnt      = '0;
		err_cnt       = 0;
		ticks_sent    = 0;
		bricks_seen   = 0;
		idle_cycles   = 0;
		sink_hold     = 0;
		sink_idle_en  = 1'b1;
		src_idle_en   = 1'b1;
		walk_px       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_and_register();
		test_trend_and_reversal();
		test_price_extremes();
		test_zero_size();
		test_random_walk();

		drain_bricks();
		repeat (8) @(posedge clk);
		$display("%0d ticks in, %0d bricks compared field by field", ticks_sent, bricks_seen);
		$display("brick heights 0, 1, 10, 65535 and random, with random gaps and backpressure");
		if (err_cnt == 0 && expected_bricks.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/rbb_pkg.sv
rtl/rbb_decide.sv
rtl/renko_brick_builder.sv
tb/sv/tb_top.sv
